// ===== hw/rtl/tcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: transaction
// structs, operation codes and the command word between front and back end.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // command queue depth between front and back end
    localparam int QUEUE_DEPTH = 2;

    // widest linear cell index over the geometry range (128 x 32 cells)
    localparam int LIN_W    = 12;
    localparam int CURSOR_W = 11;

    // function codes of an input transaction
    localparam logic [1:0] FUNC_PRINT = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // character codes
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // reset value of the default attribute (white on black)
    localparam logic [7:0] DEFAULT_ATTR_RST = 8'h0F;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_PRINT,
        OP_READ,
        OP_CLEAR
    } t_op;

    typedef enum logic [1:0] {
        PK_CHAR,
        PK_NEWLINE,
        PK_BACKSPACE
    } t_pkind;

    // input transaction
    typedef struct packed {
        logic [1:0] func;
        logic [7:0] char_code;
        logic [7:0] attr;
        logic       use_cursor;
        logic [6:0] col;
        logic [4:0] row;
    } t_item;

    // result transaction
    typedef struct packed {
        logic                status;
        logic [CURSOR_W-1:0] cursor_cell;
        logic                scrolled;
        logic [7:0]          read_char;
        logic [7:0]          read_attr;
    } t_result;

    // classified command, front end to back end
    typedef struct packed {
        t_op              op;
        t_pkind           pkind;
        logic             bad;
        logic             use_cursor;
        logic [7:0]       char_code;
        logic [7:0]       attr;
        logic [6:0]       col;
        logic [4:0]       row;
        logic [LIN_W-1:0] lin;
    } t_cmd;

endpackage

// ===== hw/rtl/tcw_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_front
// Accepts input transactions, checks the position, resolves the attribute
// and the linear cell index, and pushes a classified command to the queue.
// ----------------------------------------------------------------------------
module tcw_front #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_wdata,
    input  logic          i_push,
    input  tcw_pkg::t_item i_item,
    input  logic          i_q_full,
    input  logic          i_init_busy,
    output logic          o_full,
    output logic          o_q_push,
    output tcw_pkg::t_cmd o_cmd
);
    import tcw_pkg::*;

    logic [7:0] r_default_attr;
    logic       col_bad;
    logic       row_bad;

    // default attribute register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_attr <= DEFAULT_ATTR_RST;
        end else if (i_cfg_we) begin
            r_default_attr <= i_cfg_wdata;
        end
    end

    // handshake: hold off while the queue is full or the reset clearing pass runs
    assign o_full   = i_q_full | i_init_busy;
    assign o_q_push = i_push & ~o_full;

    // range checks
    assign col_bad = {1'b0, i_item.col} >= 8'(COLUMNS);
    assign row_bad = {1'b0, i_item.row} >= 6'(ROWS);

    // classification
    always_comb begin
        o_cmd            = '0;
        o_cmd.bad        = ~i_item.use_cursor & (col_bad | row_bad);
        o_cmd.use_cursor = i_item.use_cursor;
        o_cmd.char_code  = i_item.char_code;
        o_cmd.col        = i_item.col;
        o_cmd.row        = i_item.row;
        o_cmd.lin        = LIN_W'(i_item.row) * LIN_W'(COLUMNS) + LIN_W'(i_item.col);
        o_cmd.attr       = (i_item.attr == 8'h00) ? r_default_attr : i_item.attr;

        unique case (i_item.func)
            FUNC_PRINT: o_cmd.op = OP_PRINT;
            FUNC_READ:  o_cmd.op = OP_READ;
            FUNC_CLEAR: begin
                o_cmd.op   = OP_CLEAR;
                o_cmd.attr = r_default_attr;
            end
            default:    o_cmd.op = OP_NOP;
        endcase

        priority if (i_item.char_code == CH_NEWLINE) begin
            o_cmd.pkind = PK_NEWLINE;
        end else if (i_item.char_code == CH_BACKSPACE) begin
            o_cmd.pkind = PK_BACKSPACE;
        end else begin
            o_cmd.pkind = PK_CHAR;
        end
    end

endmodule

// ===== hw/rtl/tcw_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_queue
// Short command FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module tcw_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tcw_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output tcw_pkg::t_cmd o_cmd,
    output logic          o_empty
);
    import tcw_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/tcw_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_back
// Executes commands against the screen memory and the cursor: cell writes,
// reads, scroll and clear sweeps, and the reset clearing pass. Holds the
// result register.
// ----------------------------------------------------------------------------
module tcw_back #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tcw_pkg::t_cmd    i_q_cmd,
    input  logic             i_q_empty,
    output logic             o_q_pop,
    output logic             o_init_busy,
    input  logic             i_pop,
    output logic             o_empty,
    output tcw_pkg::t_result o_result
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);

    localparam logic [ADDR_W-1:0] LAST_CELL     = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'(CELL_COUNT - COLUMNS);
    localparam logic [ADDR_W-1:0] COPY_LAST     = ADDR_W'(CELL_COUNT - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] COLS_A        = ADDR_W'(COLUMNS);
    localparam logic [COL_W-1:0]  LAST_COL      = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW      = ROW_W'(ROWS - 1);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SCROLL_COPY,
        ST_SCROLL_FILL,
        ST_CLEAR,
        ST_RESULT
    } t_state;

    // screen memory
    logic [15:0]       mem [CELL_COUNT];
    logic [15:0]       r_rd_data;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [15:0]       mem_wd;
    logic [ADDR_W-1:0] mem_ra;

    t_state            r_state,      n_state;
    t_cmd              r_cmd,        n_cmd;
    logic [ROW_W-1:0]  r_cur_row,    n_cur_row;
    logic [COL_W-1:0]  r_cur_col,    n_cur_col;
    logic [ADDR_W-1:0] r_cur_lin,    n_cur_lin;
    logic [ADDR_W-1:0] r_cnt,        n_cnt;
    logic              r_pend_valid, n_pend_valid;
    logic [ADDR_W-1:0] r_pend_addr,  n_pend_addr;
    t_result           r_res,        n_res;
    logic              r_out_valid,  n_out_valid;
    t_result           r_out,        n_out;

    // target position of the current command
    logic [ROW_W-1:0]  p_row;
    logic [COL_W-1:0]  p_col;
    logic [ADDR_W-1:0] p_lin;
    logic              at_last_row;

    assign p_row       = r_cmd.use_cursor ? r_cur_row : ROW_W'(r_cmd.row);
    assign p_col       = r_cmd.use_cursor ? r_cur_col : COL_W'(r_cmd.col);
    assign p_lin       = r_cmd.use_cursor ? r_cur_lin : ADDR_W'(r_cmd.lin);
    assign at_last_row = p_row == LAST_ROW;

    assign o_init_busy = r_state == ST_INIT;
    assign o_empty     = ~r_out_valid;
    assign o_result    = r_out;

    // memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= mem[mem_ra];
    end

    // next-state logic
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_cur_row    = r_cur_row;
        n_cur_col    = r_cur_col;
        n_cur_lin    = r_cur_lin;
        n_cnt        = r_cnt;
        n_pend_valid = r_pend_valid;
        n_pend_addr  = r_pend_addr;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        mem_we       = 1'b0;
        mem_wa       = r_cnt;
        mem_wd       = '0;
        mem_ra       = r_cnt;
        o_q_pop      = 1'b0;

        // result register drains on pop
        if (i_pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            // clearing pass after reset
            ST_INIT: begin
                mem_we = 1'b1;
                if (r_cnt == LAST_CELL) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_state = ST_EXEC;
                end
            end

            ST_EXEC: begin
                n_res             = '0;
                n_res.cursor_cell = CURSOR_W'(r_cur_lin);
                n_state           = ST_RESULT;
                unique case (r_cmd.op)
                    OP_PRINT: begin
                        if (r_cmd.bad) begin
                            n_res.status = 1'b1;
                        end else begin
                            unique case (r_cmd.pkind)
                                PK_CHAR: begin
                                    mem_we = 1'b1;
                                    mem_wa = p_lin;
                                    mem_wd = {r_cmd.attr, r_cmd.char_code};
                                    if (p_col == LAST_COL) begin
                                        n_cur_col = '0;
                                        n_cur_row = p_row + 1'b1;
                                    end else begin
                                        n_cur_col = p_col + 1'b1;
                                        n_cur_row = p_row;
                                    end
                                    n_cur_lin = p_lin + 1'b1;
                                end
                                PK_NEWLINE: begin
                                    n_cur_col = '0;
                                    n_cur_row = p_row + 1'b1;
                                    n_cur_lin = p_lin - ADDR_W'(p_col) + COLS_A;
                                end
                                default: begin
                                    // backspace: blank the cell before, not at cell zero
                                    if (p_lin != '0) begin
                                        mem_we = 1'b1;
                                        mem_wa = p_lin - 1'b1;
                                        mem_wd = {r_cmd.attr, CH_SPACE};
                                        if (p_col == '0) begin
                                            n_cur_col = LAST_COL;
                                            n_cur_row = p_row - 1'b1;
                                        end else begin
                                            n_cur_col = p_col - 1'b1;
                                            n_cur_row = p_row;
                                        end
                                        n_cur_lin = p_lin - 1'b1;
                                    end else begin
                                        n_cur_col = '0;
                                        n_cur_row = '0;
                                        n_cur_lin = '0;
                                    end
                                end
                            endcase
                            // moving past the last row: scroll up one row
                            if (r_cmd.pkind != PK_BACKSPACE && at_last_row &&
                                (r_cmd.pkind == PK_NEWLINE || p_col == LAST_COL)) begin
                                n_cur_row         = LAST_ROW;
                                n_cur_col         = '0;
                                n_cur_lin         = LAST_ROW_BASE;
                                n_res.scrolled    = 1'b1;
                                n_res.cursor_cell = CURSOR_W'(LAST_ROW_BASE);
                                n_cnt             = '0;
                                n_pend_valid      = 1'b0;
                                n_state           = ST_SCROLL_COPY;
                            end else begin
                                n_res.cursor_cell = CURSOR_W'(n_cur_lin);
                            end
                        end
                    end
                    OP_READ: begin
                        if (r_cmd.bad) begin
                            n_res.status = 1'b1;
                        end else begin
                            mem_ra  = p_lin;
                            n_state = ST_READ;
                        end
                    end
                    OP_CLEAR: begin
                        n_cur_row         = '0;
                        n_cur_col         = '0;
                        n_cur_lin         = '0;
                        n_res.cursor_cell = '0;
                        n_cnt             = '0;
                        n_state           = ST_CLEAR;
                    end
                    default: begin
                        n_state = ST_RESULT;
                    end
                endcase
            end

            ST_READ: begin
                n_res.read_char = r_rd_data[7:0];
                n_res.read_attr = r_rd_data[15:8];
                n_state         = ST_RESULT;
            end

            // copy each cell one row up; the write of each cell trails its registered read
            ST_SCROLL_COPY: begin
                mem_ra = r_cnt + COLS_A;
                if (r_pend_valid) begin
                    mem_we = 1'b1;
                    mem_wa = r_pend_addr;
                    mem_wd = r_rd_data;
                end
                n_pend_valid = 1'b1;
                n_pend_addr  = r_cnt;
                if (r_cnt == COPY_LAST) begin
                    n_cnt   = LAST_ROW_BASE;
                    n_state = ST_SCROLL_FILL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            // finish the last copy, then zero the bottom row
            ST_SCROLL_FILL: begin
                mem_we = 1'b1;
                if (r_pend_valid) begin
                    mem_wa       = r_pend_addr;
                    mem_wd       = r_rd_data;
                    n_pend_valid = 1'b0;
                end else if (r_cnt == LAST_CELL) begin
                    n_state = ST_RESULT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wd = {r_cmd.attr, CH_SPACE};
                if (r_cnt == LAST_CELL) begin
                    n_state = ST_RESULT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            ST_RESULT: begin
                if (!r_out_valid || i_pop) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_INIT;
            r_cur_row    <= '0;
            r_cur_col    <= '0;
            r_cur_lin    <= '0;
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cur_row    <= n_cur_row;
            r_cur_col    <= n_cur_col;
            r_cur_lin    <= n_cur_lin;
            r_cnt        <= n_cnt;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
        r_cmd       <= n_cmd;
        r_pend_addr <= n_pend_addr;
        r_res       <= n_res;
        r_out       <= n_out;
    end

endmodule

// ===== hw/rtl/text_console_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: screen of character/attribute cells and a cursor.
// Print, read-cell and clear transactions, with scroll on overflow.
// ----------------------------------------------------------------------------
// Sequencing: each transaction is fetched from the queue, executed and then
//   placed in the result register; a read adds a memory read step, a print
//   that scrolls copies every row up and zeroes the bottom row, and a clear
//   writes every cell. The back end takes the next command only after the
//   result step; the queue holds up to QUEUE_DEPTH commands meanwhile.
// Reset: the cursor returns to cell 0 and a clearing pass zeroes the memory
//   while full stays high.
// ----------------------------------------------------------------------------
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_wdata,
    input  logic             push,
    input  tcw_pkg::t_item   i_item,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output tcw_pkg::t_result o_result
);
    import tcw_pkg::*;

    t_cmd front_cmd;
    t_cmd q_cmd;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    logic init_busy;

    // front end: accept and classify
    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_item      (i_item),
        .i_q_full    (q_full),
        .i_init_busy (init_busy),
        .o_full      (full),
        .o_q_push    (q_push),
        .o_cmd       (front_cmd)
    );

    // command queue
    tcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_empty (q_empty)
    );

    // back end: execute against screen memory
    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_cmd     (q_cmd),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .o_init_busy (init_busy),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule
